/* sv/rdpau_pkg.sv */
// Shared types, codes and constants for the data-ROM port address unit.
`default_nettype none
package rdpau_pkg;

  // Width of the cartridge ROM address space
  localparam int unsigned ROM_ADDR_BITS = 24;
  // Bits of the offset that address the data ROM
  localparam int unsigned OFF_BITS      = 23;
  localparam int unsigned OFFSET_W      = 24;
  localparam int unsigned ADJUST_W      = 16;
  // Smallest mapped range is 1 MiB, i.e. 2^20 bytes
  localparam logic [4:0]  RANGE_LOG2_BASE = 5'd20;
  localparam logic [4:0]  SIZE_LOG2_FULL  = 5'd23;

  // Mask applied to the rebased address
  localparam logic [23:0] ADDR_MASK = (ROM_ADDR_BITS >= 24) ? 24'hff_ffff :
                                      24'((32'd1 << ROM_ADDR_BITS) - 32'd1);

  // Request event codes
  typedef enum logic [2:0] {
    EV_INC_A      = 3'd0,
    EV_INC_B      = 3'd1,
    EV_INC_ADJ_WR = 3'd2,
    EV_WR_OFFSET  = 3'd3,
    EV_WR_ADJUST  = 3'd4
  } event_t;

  // Increment style field of the mode bits
  typedef enum logic [2:0] {
    STYLE_BYTE = 3'd1,
    STYLE_WORD = 3'd2,
    STYLE_B    = 3'd3
  } style_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_BANK_SIZE = 3'd1,
    REG_ROM_LOG2  = 3'd2,
    REG_ROM_BASE  = 3'd3,
    REG_STEP      = 3'd4
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]  mode_bits;
    logic [1:0]  bank_size_select;
    logic [4:0]  rom_size_log2;
    logic [23:0] rom_base;
    logic [15:0] step_value;
  } cfg_t;

  // Adjust widened to offset width, signed when mode bit 3 is set
  function automatic logic [23:0] adj_ext(input logic [7:0] mb, input logic [15:0] adj);
    adj_ext = mb[3] ? {{8{adj[15]}}, adj} : {8'b0, adj};
  endfunction

endpackage
`default_nettype wire

/* sv/rom_data_port_address_unit.sv */
// Top level of the data-ROM port address unit.
// Usage:
//   Input channel in_*: each request is one event; in_tuser[2:0] carries the
//   event code and in_tdata[23:0] the write value. The offset and adjust
//   registers are updated at the edge the request is taken.
//   Output channel out_*: one result per request with both port addresses,
//   their blank flags and the offset and adjust after the event.
//   Configuration channel cfg_*: cfg_index selects mode bits, bank size,
//   ROM size, ROM base or step value; cfg_ready is always high. Write only
//   while no request is in flight.
// Timing: the state registers take the update at the accepting edge, and
//   the address mapping loads the output register at a later edge, once
//   the output register has space.
// Throughput: one request per cycle while out_tready is high; the state registers update as each request is taken.
// Reset: offset and adjust clear, configuration returns to its defaults,
//   both pipeline stages empty.
// Stall: when out_tready is low the output register holds; one more request
//   is taken into the update stage, then in_tready drops until space frees.
`default_nettype none
module rom_data_port_address_unit
  import rdpau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // [23:0] write_value, [31:24] zero
  input  wire logic [2:0]  in_tuser,  // [2:0] event code
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata  // [23:0] rom_addr_a, [24] blank_a,
                                      // [48:25] rom_addr_b, [49] blank_b,
                                      // [73:50] offset_now, [89:74] adjust_now,
                                      // [95:90] zero
);

  cfg_t        cfg_r;
  logic [23:0] offset_r;
  logic [15:0] adjust_r;
  logic [23:0] offset_nxt;
  logic [15:0] adjust_nxt;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [89:0] out_data_r;
  logic        in_acc;
  logic        out_load;
  logic [23:0] adj24;
  logic [23:0] sum_ab;
  logic [23:0] addr_a_in;
  logic [23:0] rom_addr_a;
  logic [23:0] rom_addr_b;
  logic        blank_a;
  logic        blank_b;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_bits        <= 8'd0;
      cfg_r.bank_size_select <= 2'd0;
      cfg_r.rom_size_log2    <= 5'd22;
      cfg_r.rom_base         <= 24'h10_0000;
      cfg_r.step_value       <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:      cfg_r.mode_bits        <= cfg_data[7:0];
        REG_BANK_SIZE: cfg_r.bank_size_select <= cfg_data[1:0];
        REG_ROM_LOG2:  cfg_r.rom_size_log2    <= cfg_data[4:0];
        REG_ROM_BASE:  cfg_r.rom_base         <= cfg_data;
        REG_STEP:      cfg_r.step_value       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake control for the two stages
  assign out_load     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !s1_valid_r || out_load;
  assign in_acc       = in_tvalid && in_tready;
  assign s1_valid_nxt = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // State update stage
  rdpau_update u_update (
    .cfg         (cfg_r),
    .ev          (in_tuser),
    .write_value (in_tdata[23:0]),
    .offset      (offset_r),
    .adjust      (adjust_r),
    .offset_nxt  (offset_nxt),
    .adjust_nxt  (adjust_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 24'd0;
      adjust_r <= 16'd0;
    end else if (in_acc) begin
      offset_r <= offset_nxt;
      adjust_r <= adjust_nxt;
    end
  end

  // Port address mapping from the updated state
  assign adj24     = adj_ext(cfg_r.mode_bits, adjust_r);
  assign sum_ab    = offset_r + adj24;
  assign addr_a_in = cfg_r.mode_bits[1] ? sum_ab : offset_r;

  rdpau_port u_port_a (
    .cfg      (cfg_r),
    .addr_in  (addr_a_in),
    .rom_addr (rom_addr_a),
    .blank    (blank_a)
  );

  rdpau_port u_port_b (
    .cfg      (cfg_r),
    .addr_in  (sum_ab),
    .rom_addr (rom_addr_b),
    .blank    (blank_b)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {adjust_r, offset_r, blank_b, rom_addr_b, blank_a, rom_addr_a};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  // An accepted request always occupies the update stage next cycle
  a_acc_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request lost from update stage");

  // The update stage holds its request until the output register takes it
  a_s1_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load && !in_acc) |=> s1_valid_r)
    else $error("update stage dropped a request");

  // Back-pressure only when both stages are full and the receiver stalls
  a_ready_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without cause");

  // An offset write lands in the offset register
  a_wr_offset : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == EV_WR_OFFSET) |=> offset_r == $past(in_tdata[23:0]))
    else $error("offset write not applied");

endmodule
`default_nettype wire

/* sv/rdpau_update.sv */
// Next offset and adjust for one event.
`default_nettype none
module rdpau_update
  import rdpau_pkg::*;
(
  input  wire cfg_t        cfg,
  input  wire logic [2:0]  ev,
  input  wire logic [23:0] write_value,
  input  wire logic [23:0] offset,
  input  wire logic [15:0] adjust,
  output logic      [23:0] offset_nxt,
  output logic      [15:0] adjust_nxt
);

  logic [23:0] adj24;
  logic [15:0] inc16;
  logic [23:0] inc24;
  logic [23:0] byte24;
  logic [2:0]  style;

  assign adj24  = adj_ext(cfg.mode_bits, adjust);
  assign inc16  = cfg.mode_bits[0] ? cfg.step_value : 16'd1;
  assign inc24  = cfg.mode_bits[2] ? {{8{inc16[15]}}, inc16} : {8'b0, inc16};
  assign byte24 = cfg.mode_bits[3] ? {{16{adjust[7]}}, adjust[7:0]} : {16'b0, adjust[7:0]};
  assign style  = cfg.mode_bits[7:5];

  // Apply the event to the offset and adjust
  always_comb begin
    offset_nxt = offset;
    adjust_nxt = adjust;
    case (ev)
      EV_INC_A: begin
        if (cfg.mode_bits[1]) begin
          adjust_nxt = adjust + 16'd1;
        end else if (cfg.mode_bits[4]) begin
          adjust_nxt = adjust + inc16;
        end else begin
          offset_nxt = offset + inc24;
        end
      end
      EV_INC_B: begin
        if (style == STYLE_B) begin
          if (cfg.mode_bits[4]) begin
            adjust_nxt = adjust + adjust;
          end else begin
            offset_nxt = offset + adj24;
          end
        end
      end
      EV_INC_ADJ_WR: begin
        if (cfg.mode_bits[1] && !cfg.mode_bits[4]) begin
          if (style == STYLE_BYTE) begin
            offset_nxt = offset + byte24;
          end else if (style == STYLE_WORD) begin
            offset_nxt = offset + adj24;
          end
        end
      end
      EV_WR_OFFSET: offset_nxt = write_value;
      EV_WR_ADJUST: adjust_nxt = write_value[15:0];
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/rdpau_port.sv */
// Maps one data port offset onto a ROM byte address with its blank flag.
`default_nettype none
module rdpau_port
  import rdpau_pkg::*;
(
  input  wire cfg_t        cfg,
  input  wire logic [23:0] addr_in,
  output logic      [23:0] rom_addr,
  output logic             blank
);

  logic [OFF_BITS-1:0] off;
  logic [OFF_BITS-1:0] size_mask;
  logic                full_size;
  logic                range_fits;
  logic                beyond;
  logic [23:0]         rebased;

  assign off        = addr_in[OFF_BITS-1:0];
  assign full_size  = cfg.rom_size_log2 >= SIZE_LOG2_FULL;
  // Mapped range of 2^(20+sel) bytes against the ROM size
  assign range_fits = (RANGE_LOG2_BASE + {3'b0, cfg.bank_size_select}) <= cfg.rom_size_log2;
  assign size_mask  = full_size ? {OFF_BITS{1'b1}} :
                      ~({OFF_BITS{1'b1}} << cfg.rom_size_log2);
  assign beyond     = !full_size && (|(off & ~size_mask));
  assign blank      = range_fits && beyond;
  assign rebased    = (cfg.rom_base + {1'b0, off & size_mask}) & ADDR_MASK;
  assign rom_addr   = blank ? 24'd0 : rebased;

endmodule
`default_nettype wire
